/* design/raot_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relay auto-off timer package
// Command codes, field widths and constants for the relay timer block.
// ----------------------------------------------------------------------------
package raot_pkg;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned MIN_W  = 16;
  localparam int unsigned SEC_W  = 22;
  localparam int unsigned MS_W   = 10;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET_ENABLE   = 3'd0,
    MODE_TURN_ON      = 3'd1,
    MODE_TURN_OFF     = 3'd2,
    MODE_TURN_ON_TIMED = 3'd3,
    MODE_TOGGLE       = 3'd4,
    MODE_TICK_1MS     = 3'd5,
    MODE_FORCE_REPORT = 3'd6
  } mode_t;

  localparam logic [MIN_W-1:0] DEFAULT_MINUTES_RST = 16'd60;
  localparam logic [MS_W-1:0]  MS_LAST             = 10'd999;

endpackage

/* design/relay_auto_off_timer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relay auto-off timer
// Throughput: one command per cycle while the output is not stalled; a command
// waits in the input register, and its state update is a single pass from the
// input register into the state and result registers that hold any report.
// Reset: synchronous, active low; enable on, relay off, timer stopped,
// default length 60 minutes, no report emitted until a reporting command.
// ----------------------------------------------------------------------------
module relay_auto_off_timer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,    // default_minutes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // enable_value, duration_minutes, zero fill
  input  logic [2:0]  in_tuser,    // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata    // enabled, relay_on, remaining_seconds
);

  localparam int unsigned MIN_W = raot_pkg::MIN_W;
  localparam int unsigned SEC_W = raot_pkg::SEC_W;
  localparam int unsigned MS_W  = raot_pkg::MS_W;

  logic [MIN_W-1:0] default_minutes_r;

  logic                        in_valid_r;
  logic [raot_pkg::MODE_W-1:0] in_mode_r;
  logic                        in_en_r;
  logic [MIN_W-1:0]            in_dur_r;
  logic                        advance;

  logic             master_enable_r, master_enable_nxt;
  logic             relay_level_r, relay_level_nxt;
  logic             timer_running_r, timer_running_nxt;
  logic [SEC_W-1:0] seconds_left_r, seconds_left_nxt;
  logic [MS_W-1:0]  millis_r, millis_nxt;
  logic             rep_enable_r, rep_enable_nxt;
  logic             rep_relay_r, rep_relay_nxt;
  logic [SEC_W-1:0] rep_seconds_r, rep_seconds_nxt;
  logic             rep_valid_r, rep_valid_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [23:0]      out_data_r, out_data_nxt;

  logic [MIN_W-1:0] minutes_sel;
  logic [SEC_W-1:0] timed_seconds;
  logic             do_report;
  logic             force_report;
  logic             emit;
  logic             cur_rl;
  logic [SEC_W-1:0] cur_secs;
  logic [SEC_W-1:0] tick_secs;
  logic [MS_W-1:0]  tick_ms;

  assign cfg_ready  = 1'b1;
  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_minutes_r <= raot_pkg::DEFAULT_MINUTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      default_minutes_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_mode_r <= in_tuser;
      in_en_r   <= in_tdata[0];
      in_dur_r  <= in_tdata[16:1];
    end
  end

  // Minutes to seconds as (m << 6) - (m << 2); the largest value fits 22 bits.
  always_comb begin
    if (raot_pkg::mode_t'(in_mode_r) == raot_pkg::MODE_TURN_ON_TIMED && in_dur_r != '0) begin
      minutes_sel = in_dur_r;
    end else begin
      minutes_sel = default_minutes_r;
    end
    timed_seconds = ({{(SEC_W-MIN_W){1'b0}}, minutes_sel} << 6)
                  - ({{(SEC_W-MIN_W){1'b0}}, minutes_sel} << 2);
  end

  always_comb begin
    if (millis_r != '0) begin
      tick_secs = seconds_left_r;
      tick_ms   = millis_r - 1'b1;
    end else if (seconds_left_r != '0) begin
      tick_secs = seconds_left_r - 1'b1;
      tick_ms   = raot_pkg::MS_LAST;
    end else begin
      tick_secs = seconds_left_r;
      tick_ms   = millis_r;
    end
  end

  always_comb begin
    master_enable_nxt = master_enable_r;
    relay_level_nxt   = relay_level_r;
    timer_running_nxt = timer_running_r;
    seconds_left_nxt  = seconds_left_r;
    millis_nxt        = millis_r;
    do_report         = 1'b0;
    force_report      = 1'b0;

    case (raot_pkg::mode_t'(in_mode_r))
      raot_pkg::MODE_SET_ENABLE: begin
        if (master_enable_r != in_en_r) begin
          master_enable_nxt = in_en_r;
          do_report         = 1'b1;
          if (in_en_r) begin
            force_report = 1'b1;
          end else begin
            timer_running_nxt = 1'b0;
            seconds_left_nxt  = '0;
            millis_nxt        = '0;
            relay_level_nxt   = 1'b0;
          end
        end
      end
      raot_pkg::MODE_TURN_ON: begin
        if (master_enable_r) begin
          timer_running_nxt = 1'b0;
          seconds_left_nxt  = '0;
          millis_nxt        = '0;
          relay_level_nxt   = 1'b1;
          do_report         = 1'b1;
        end
      end
      raot_pkg::MODE_TURN_OFF: begin
        timer_running_nxt = 1'b0;
        seconds_left_nxt  = '0;
        millis_nxt        = '0;
        relay_level_nxt   = 1'b0;
        do_report         = 1'b1;
      end
      raot_pkg::MODE_TURN_ON_TIMED, raot_pkg::MODE_TOGGLE: begin
        if (master_enable_r) begin
          do_report = 1'b1;
          if (raot_pkg::mode_t'(in_mode_r) == raot_pkg::MODE_TOGGLE && relay_level_r) begin
            timer_running_nxt = 1'b0;
            seconds_left_nxt  = '0;
            millis_nxt        = '0;
            relay_level_nxt   = 1'b0;
          end else begin
            timer_running_nxt = 1'b1;
            seconds_left_nxt  = timed_seconds;
            millis_nxt        = '0;
            relay_level_nxt   = 1'b1;
          end
        end
      end
      raot_pkg::MODE_TICK_1MS: begin
        if (!master_enable_r) begin
          do_report = 1'b1;
        end else if (timer_running_r && relay_level_r) begin
          do_report  = 1'b1;
          if (tick_secs == '0 && tick_ms == '0) begin
            timer_running_nxt = 1'b0;
            seconds_left_nxt  = '0;
            millis_nxt        = '0;
            relay_level_nxt   = 1'b0;
          end else begin
            seconds_left_nxt = tick_secs;
            millis_nxt       = tick_ms;
          end
        end
      end
      raot_pkg::MODE_FORCE_REPORT: begin
        do_report    = 1'b1;
        force_report = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cur_rl   = master_enable_nxt && relay_level_nxt;
    cur_secs = (timer_running_nxt && relay_level_nxt && master_enable_nxt)
             ? seconds_left_nxt : '0;
    emit = do_report && (force_report || !rep_valid_r || rep_enable_r != master_enable_nxt
                         || rep_relay_r != cur_rl || rep_seconds_r != cur_secs);

    rep_enable_nxt  = rep_enable_r;
    rep_relay_nxt   = rep_relay_r;
    rep_seconds_nxt = rep_seconds_r;
    rep_valid_nxt   = rep_valid_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    if (emit) begin
      rep_enable_nxt  = master_enable_nxt;
      rep_relay_nxt   = cur_rl;
      rep_seconds_nxt = cur_secs;
      rep_valid_nxt   = 1'b1;
      out_valid_nxt   = 1'b1;
      out_data_nxt    = {cur_secs, cur_rl, master_enable_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_enable_r <= 1'b1;
      relay_level_r   <= 1'b0;
      timer_running_r <= 1'b0;
      seconds_left_r  <= '0;
      millis_r        <= '0;
      rep_enable_r    <= 1'b1;
      rep_relay_r     <= 1'b0;
      rep_seconds_r   <= '0;
      rep_valid_r     <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (advance) begin
        master_enable_r <= master_enable_nxt;
        relay_level_r   <= relay_level_nxt;
        timer_running_r <= timer_running_nxt;
        seconds_left_r  <= seconds_left_nxt;
        millis_r        <= millis_nxt;
        rep_enable_r    <= rep_enable_nxt;
        rep_relay_r     <= rep_relay_nxt;
        rep_seconds_r   <= rep_seconds_nxt;
        rep_valid_r     <= rep_valid_nxt;
        out_valid_r     <= out_valid_nxt;
      end else begin
        out_valid_r <= out_valid_r && !out_tready;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

/* sim/tb_relay_auto_off_timer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relay auto-off timer testbench
// Sends commands into the relay timer and compares every report it returns
// with an in-bench prediction of enable, relay level and remaining seconds.
// Directed tests come first, then a timed-run countdown, a long output
// stall, and random traffic under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_relay_auto_off_timer_top;

  localparam int unsigned MODE_W = raot_pkg::MODE_W;
  localparam int unsigned MIN_W  = raot_pkg::MIN_W;
  localparam int unsigned SEC_W  = raot_pkg::SEC_W;
  localparam int unsigned MS_W   = raot_pkg::MS_W;

  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  typedef struct packed {
    logic             enabled;
    logic             relay_on;
    logic [SEC_W-1:0] secs;
  } report_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;    // enable_value, duration_minutes, zero fill
  logic [2:0]  in_tuser   = '0;    // mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // enabled, relay_on, remaining_seconds

  report_t pending_reports[$];
  report_t head_report;
  int      errors          = 0;
  int      reports_checked = 0;
  int      commands_sent   = 0;
  int      cycle_count     = 0;
  int      send_idle_pct   = 0;
  int      recv_stall_pct  = 0;
  int      hold_len        = 0;

  logic [MIN_W-1:0] shadow_default_min;
  logic             shadow_enable;
  logic             shadow_relay;
  logic             shadow_timing;
  logic [SEC_W-1:0] shadow_secs;
  logic [MS_W-1:0]  shadow_ms;
  logic             last_enable;
  logic             last_relay;
  logic [SEC_W-1:0] last_secs;
  logic             have_last;

  relay_auto_off_timer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void reset_shadow();
    shadow_default_min = raot_pkg::DEFAULT_MINUTES_RST;
    shadow_enable      = 1'b1;
    shadow_relay       = 1'b0;
    shadow_timing      = 1'b0;
    shadow_secs        = '0;
    shadow_ms          = '0;
    last_enable        = 1'b1;
    last_relay         = 1'b0;
    last_secs          = '0;
    have_last          = 1'b0;
  endfunction

  function automatic void stop_countdown();
    shadow_timing = 1'b0;
    shadow_secs   = '0;
    shadow_ms     = '0;
  endfunction

  function automatic bit report_if_changed(input bit forced, output report_t rpt);
    rpt.enabled  = shadow_enable;
    rpt.relay_on = shadow_enable && shadow_relay;
    rpt.secs     = (shadow_timing && shadow_relay && shadow_enable) ? shadow_secs : '0;
    if (!forced && have_last && last_enable == rpt.enabled &&
        last_relay == rpt.relay_on && last_secs == rpt.secs)
      return 1'b0;
    last_enable = rpt.enabled;
    last_relay  = rpt.relay_on;
    last_secs   = rpt.secs;
    have_last   = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit switch_off(output report_t rpt);
    stop_countdown();
    shadow_relay = 1'b0;
    return report_if_changed(1'b0, rpt);
  endfunction

  function automatic bit start_countdown(input logic [MIN_W-1:0] minutes, output report_t rpt);
    int unsigned length_min;
    length_min    = 32'((minutes != 0) ? minutes : shadow_default_min);
    shadow_timing = 1'b1;
    shadow_secs   = SEC_W'(length_min * SECS_PER_MIN);
    shadow_ms     = '0;
    shadow_relay  = 1'b1;
    return report_if_changed(1'b0, rpt);
  endfunction

  function automatic bit predict_report(input logic [MODE_W-1:0] mode, input logic en_val,
                                        input logic [MIN_W-1:0] minutes,
                                        output report_t rpt);
    rpt = '0;
    case (mode)
      raot_pkg::MODE_SET_ENABLE: begin
        if (shadow_enable == en_val) return 1'b0;
        shadow_enable = en_val;
        if (!en_val) begin
          stop_countdown();
          shadow_relay = 1'b0;
          return report_if_changed(1'b0, rpt);
        end
        return report_if_changed(1'b1, rpt);
      end
      raot_pkg::MODE_TURN_ON: begin
        if (!shadow_enable) return 1'b0;
        stop_countdown();
        shadow_relay = 1'b1;
        return report_if_changed(1'b0, rpt);
      end
      raot_pkg::MODE_TURN_OFF: return switch_off(rpt);
      raot_pkg::MODE_TURN_ON_TIMED: begin
        if (!shadow_enable) return 1'b0;
        return start_countdown(minutes, rpt);
      end
      raot_pkg::MODE_TOGGLE: begin
        if (!shadow_enable) return 1'b0;
        if (shadow_relay) return switch_off(rpt);
        return start_countdown('0, rpt);
      end
      raot_pkg::MODE_TICK_1MS: begin
        if (!shadow_enable) return report_if_changed(1'b0, rpt);
        if (!(shadow_timing && shadow_relay)) return 1'b0;
        if (shadow_ms != 0) begin
          shadow_ms = shadow_ms - 1'b1;
        end else if (shadow_secs != 0) begin
          shadow_secs = shadow_secs - 1'b1;
          shadow_ms   = raot_pkg::MS_LAST;
        end
        if (shadow_secs == 0 && shadow_ms == 0) return switch_off(rpt);
        return report_if_changed(1'b0, rpt);
      end
      raot_pkg::MODE_FORCE_REPORT: return report_if_changed(1'b1, rpt);
      default: return 1'b0;
    endcase
  endfunction

  always @(negedge clk) begin
    if (hold_len != 0) begin
      out_tready <= 1'b0;
      hold_len = hold_len - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report transfer: tdata %h", out_tdata);
        errors++;
      end else begin
        head_report = pending_reports.pop_front();
        reports_checked++;
        if (out_tdata[0] !== head_report.enabled) begin
          $error("enabled: expected %0d, got %0d", head_report.enabled, out_tdata[0]);
          errors++;
        end
        if (out_tdata[1] !== head_report.relay_on) begin
          $error("relay_on: expected %0d, got %0d", head_report.relay_on, out_tdata[1]);
          errors++;
        end
        if (out_tdata[23:2] !== head_report.secs) begin
          $error("remaining_seconds: expected %0d, got %0d", head_report.secs,
                 out_tdata[23:2]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Called and left at a falling edge.
  task automatic send_command(input logic [MODE_W-1:0] mode, input logic en_val,
                              input logic [MIN_W-1:0] minutes);
    report_t rpt;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {7'b0, minutes, en_val};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    commands_sent++;
    if (predict_report(mode, en_val, minutes, rpt)) pending_reports.push_back(rpt);
    @(negedge clk);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_command(raot_pkg::MODE_TICK_1MS, 1'($urandom_range(1)), 16'($urandom));
  endtask

  task automatic wait_for_reports();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_default_minutes(input logic [MIN_W-1:0] value);
    wait_for_reports();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_default_min = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_first_report();
    send_command(raot_pkg::MODE_TURN_OFF, 1'b1, 16'hFFFF);
    send_command(raot_pkg::MODE_FORCE_REPORT, 1'b0, 16'h0000);
  endtask

  task automatic test_enable_control();
    send_command(raot_pkg::MODE_SET_ENABLE, 1'b1, 16'h0000);
    send_command(raot_pkg::MODE_TURN_ON, 1'b0, 16'h0000);
    send_command(raot_pkg::MODE_SET_ENABLE, 1'b0, 16'hFFFF);
    send_command(raot_pkg::MODE_TURN_ON, 1'b1, 16'h0001);
    send_command(raot_pkg::MODE_TURN_ON_TIMED, 1'b1, 16'h0005);
    send_command(raot_pkg::MODE_TOGGLE, 1'b1, 16'h0000);
    send_command(raot_pkg::MODE_TURN_OFF, 1'b0, 16'h0000);
    send_command(raot_pkg::MODE_TICK_1MS, 1'b0, 16'h0000);
    send_command(raot_pkg::MODE_SET_ENABLE, 1'b0, 16'h0000);
    send_command(raot_pkg::MODE_SET_ENABLE, 1'b1, 16'h8000);
  endtask

  task automatic test_relay_commands();
    send_command(raot_pkg::MODE_TOGGLE, 1'b0, 16'h0000);
    send_command(raot_pkg::MODE_TURN_ON_TIMED, 1'b1, 16'hFFFF);
    send_command(raot_pkg::MODE_TICK_1MS, 1'b1, 16'hFFFF);
    send_command(raot_pkg::MODE_TOGGLE, 1'b0, 16'h0000);
    send_command(raot_pkg::MODE_TURN_ON, 1'b1, 16'h0000);
    send_command(raot_pkg::MODE_TICK_1MS, 1'b0, 16'h0000);
    send_command(MODE_UNUSED, 1'b1, 16'hFFFF);
    send_command(raot_pkg::MODE_FORCE_REPORT, 1'b1, 16'hFFFF);
    send_command(raot_pkg::MODE_TURN_OFF, 1'b0, 16'h0000);
  endtask

  task automatic test_zero_length_run();
    write_default_minutes('0);
    send_command(raot_pkg::MODE_TURN_ON_TIMED, 1'b0, 16'h0000);
    send_command(raot_pkg::MODE_TICK_1MS, 1'b0, 16'h0000);
    send_command(raot_pkg::MODE_TOGGLE, 1'b1, 16'h0000);
    send_command(raot_pkg::MODE_TICK_1MS, 1'b1, 16'h0000);
    write_default_minutes(raot_pkg::DEFAULT_MINUTES_RST);
  endtask

  task automatic test_timer_countdown();
    send_command(raot_pkg::MODE_TURN_ON_TIMED, 1'b1, 16'h0001);
    send_ticks(5);
    send_command(raot_pkg::MODE_TURN_ON_TIMED, 1'b1, 16'h0000);
    send_command(raot_pkg::MODE_TOGGLE, 1'b0, 16'h0000);
    wait_for_reports();
  endtask

  task automatic test_output_stall();
    send_command(raot_pkg::MODE_SET_ENABLE, 1'b1, 16'h0000);
    @(posedge clk);
    hold_len = 300;
    @(negedge clk);
    repeat (40) begin
      send_command(raot_pkg::MODE_TURN_ON, 1'($urandom_range(1)), 16'($urandom));
      send_command(raot_pkg::MODE_TURN_OFF, 1'($urandom_range(1)), 16'($urandom));
    end
    wait_for_reports();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [MIN_W-1:0] default_min, input int steps);
    int               pick;
    logic [MIN_W-1:0] minutes;
    write_default_minutes(default_min);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (steps) begin
      pick = $urandom_range(99);
      if (pick < 50) minutes = '0;
      else if (pick < 80) minutes = MIN_W'($urandom_range(3, 1));
      else minutes = MIN_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 2) begin
        send_command(raot_pkg::MODE_TURN_ON_TIMED, 1'($urandom_range(1)),
                     MIN_W'($urandom_range(2)));
        send_ticks($urandom_range(8, 1));
      end else if (pick < 32) begin
        send_ticks($urandom_range(8, 1));
      end else if (pick < 36) begin
        send_command(raot_pkg::MODE_SET_ENABLE, 1'b1, minutes);
      end else begin
        send_command(MODE_W'($urandom_range(7)), 1'($urandom_range(1)), minutes);
      end
    end
    wait_for_reports();
  endtask

  initial begin
    reset_shadow();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_first_report();
    test_enable_control();
    test_relay_commands();
    test_zero_length_run();
    test_timer_countdown();
    test_output_stall();
    test_random_traffic(0, 0, 16'hFFFF, 85);
    test_random_traffic(81, 0, 16'h0001, 85);
    test_random_traffic(0, 81, 16'h0000, 85);
    test_random_traffic(9, 9, MIN_W'($urandom), 85);
    wait_for_reports();
    if (pending_reports.size() != 0) begin
      $error("%0d expected reports never arrived", pending_reports.size());
      errors++;
    end
    $display("Sent %0d commands and checked %0d reports in %0d cycles.",
             commands_sent, reports_checked, cycle_count);
    $display("Covered enable control, timed runs to expiry, output stalls and idle mixes.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
